/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

`define ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(expr)) \
		else $error(msg);

`else

`define ASSERT_PROP(lbl, clk_sig, rst_n_sig, prop, msg)

`define ASSERT_NEVER(lbl, clk_sig, rst_n_sig, expr, msg)

`endif

`endif

/* src/fss_pkg.sv */
// ----------------------------------------------------------------------------
// fss_pkg
// Types, constants and helpers shared by the fuzzy subsequence scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package fss_pkg;

	localparam int QUERY_CAP_DEF = 256;
	localparam int CAND_CAP_DEF  = 1024;

	localparam int CHAR_W  = 8;
	localparam int SCORE_W = 11;
	localparam int BEST_W  = 10;
	localparam int MLEN_W  = 9;

	localparam logic [SCORE_W-1:0] CELL_MAX = {SCORE_W{1'b1}};
	localparam logic [BEST_W-1:0]  BEST_MAX = {BEST_W{1'b1}};

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_CHAR   = 2'd2,
		ACT_END    = 2'd3
	} action_t;

	// Word handed from one cell to the next. The scores are the row's values
	// from before the column that travels with them.
	typedef struct packed {
		logic               valid;
		logic [CHAR_W-1:0]  ch;
		logic [SCORE_W-1:0] pmax;
		logic [SCORE_W-1:0] pcol;
		logic               tok;
		logic [SCORE_W-1:0] tok_val;
	} fss_link_t;

	typedef struct packed {
		logic              clr;
		logic              wr;
		logic [CHAR_W-1:0] wr_char;
	} fss_ctrl_t;

	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* src/fss_cell.sv */
// ----------------------------------------------------------------------------
// fss_cell
// One query row: holds its character and running scores, passes the column on.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_cell import fss_pkg::*; #(
	parameter int QUERY_CAPACITY = QUERY_CAP_DEF,
	parameter int IDX = 0,
	localparam int QLW = $clog2(QUERY_CAPACITY + 1)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire fss_ctrl_t      ctrl,
	input  wire logic [QLW-1:0] qlen,
	input  wire fss_link_t      link_in,
	output fss_link_t           link_out
);

	localparam logic [QLW-1:0] MY_IDX   = QLW'(IDX);
	localparam logic [QLW-1:0] LAST_LEN = QLW'(IDX + 1);

	logic [CHAR_W-1:0]  qchar_q;
	logic [SCORE_W-1:0] pmax_q;
	logic [SCORE_W-1:0] pcol_q;
	fss_link_t          link_q;

	logic               is_last;
	logic               hit;
	logic [SCORE_W:0]   b1;
	logic [SCORE_W:0]   b3;
	logic [SCORE_W:0]   bmax;
	logic [SCORE_W-1:0] chained;
	logic [SCORE_W-1:0] cell_score;

	assign is_last = (qlen == LAST_LEN);
	assign hit     = (qchar_q == link_in.ch);

	always_comb begin
		b1 = (link_in.pmax != '0) ? ({1'b0, link_in.pmax} + (SCORE_W+1)'(1)) : '0;
		b3 = (link_in.pcol != '0) ? ({1'b0, link_in.pcol} + (SCORE_W+1)'(3)) : '0;
		bmax = (b3 > b1) ? b3 : b1;
		chained = (bmax > {1'b0, CELL_MAX}) ? CELL_MAX : bmax[SCORE_W-1:0];
		if (!hit) begin
			cell_score = '0;
		end else if (IDX == 0) begin
			cell_score = SCORE_W'(1);
		end else begin
			cell_score = chained;
		end
	end

	// Query characters are stored already folded.
	always_ff @(posedge clk) begin
		if (ctrl.wr && qlen == MY_IDX) begin
			qchar_q <= ctrl.wr_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmax_q <= '0;
			pcol_q <= '0;
			link_q <= '0;
		end else if (ctrl.clr) begin
			pmax_q <= '0;
			pcol_q <= '0;
			link_q <= '0;
		end else begin
			link_q.valid   <= link_in.valid;
			link_q.ch      <= link_in.ch;
			link_q.pmax    <= pmax_q;
			link_q.pcol    <= pcol_q;
			link_q.tok     <= link_in.tok;
			link_q.tok_val <= (link_in.tok && is_last) ? pmax_q : link_in.tok_val;
			if (link_in.valid) begin
				pcol_q <= cell_score;
				if (cell_score > pmax_q) begin
					pmax_q <= cell_score;
				end
			end else if (link_in.tok) begin
				// The end word follows the last column, so the row can start over.
				pmax_q <= '0;
				pcol_q <= '0;
			end
		end
	end

	assign link_out = link_q;

endmodule

`default_nettype wire

/* src/fuzzy_subsequence_scorer.sv */
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer
// Case-insensitive fuzzy subsequence scoring over a chain of query-row cells.
// ----------------------------------------------------------------------------
// Clear, append, candidate character and end words are taken only while busy
// is low, and while busy is low a candidate streams in at one character per
// clock. Each query row is a cell of a systolic chain of QUERY_CAPACITY
// cells; a column moves one cell per cycle. An end-candidate word travels
// down the whole chain behind the last column and picks up the last row's
// best score on the way, and busy stays high until it leaves the last cell.
// The result is shown for exactly one cycle with done high, in the first
// cycle that busy is low again; the receiver cannot stall and must take it
// then. There is no clearing pass after reset: the row state is cleared as
// the end word passes and at once on a clear or append.
`default_nettype none

module fuzzy_subsequence_scorer import fss_pkg::*; #(
	parameter int QUERY_CAPACITY     = QUERY_CAP_DEF,
	parameter int CANDIDATE_CAPACITY = CAND_CAP_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        action,
	input  wire logic [CHAR_W-1:0] char_byte,
	output logic                   done,
	output logic [BEST_W-1:0]      top_score,
	output logic                   matched,
	output logic [MLEN_W-1:0]      match_length,
	output logic                   too_long
);

	`include "assert_macros.svh"

	localparam int QLW = $clog2(QUERY_CAPACITY + 1);
	localparam int CLW = $clog2(CANDIDATE_CAPACITY + 2);
	localparam logic [QLW-1:0] QCAP     = QLW'(QUERY_CAPACITY);
	localparam logic [CLW-1:0] CCAP     = CLW'(CANDIDATE_CAPACITY);
	localparam logic [CLW-1:0] CCAP_SAT = CLW'(CANDIDATE_CAPACITY + 1);

	logic [QLW-1:0] qlen_q;
	logic           qovf_q;
	logic [CLW-1:0] clen_q;
	logic           busy_q;
	fss_link_t      link0_q;
	logic           done_q;
	logic [BEST_W-1:0] best_q;
	logic              matched_q;
	logic [MLEN_W-1:0] mlen_q;
	logic              too_long_q;

	fss_link_t      links [QUERY_CAPACITY+1];
	fss_ctrl_t      ctrl;
	logic           accept;
	action_t        act;
	logic           is_clear;
	logic           is_append;
	logic           is_char;
	logic           is_end;
	fss_link_t      chain_out;

	logic [BEST_W-1:0] best_d;
	logic              too_long_d;
	logic [QLW+MLEN_W-1:0] qlen_wide;

	assign accept = start && !busy_q;
	assign act    = action_t'(action);

	always_comb begin
		is_clear  = 1'b0;
		is_append = 1'b0;
		is_char   = 1'b0;
		is_end    = 1'b0;
		unique case (act)
			ACT_CLEAR:  is_clear  = accept;
			ACT_APPEND: is_append = accept;
			ACT_CHAR:   is_char   = accept;
			ACT_END:    is_end    = accept;
			default:    is_clear  = 1'b0;
		endcase
	end

	// A query change restarts the candidate and flushes columns in flight.
	assign ctrl.clr     = is_clear || is_append;
	assign ctrl.wr      = is_append && (qlen_q < QCAP);
	assign ctrl.wr_char = fold_case(char_byte);

	assign links[0] = link0_q;

	genvar gi;
	generate
		for (gi = 0; gi < QUERY_CAPACITY; gi++) begin : g_cell
			fss_cell #(
				.QUERY_CAPACITY(QUERY_CAPACITY),
				.IDX(gi)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctrl(ctrl),
				.qlen(qlen_q),
				.link_in(links[gi]),
				.link_out(links[gi+1])
			);
		end
	endgenerate

	assign chain_out = links[QUERY_CAPACITY];
	assign qlen_wide = {{MLEN_W{1'b0}}, qlen_q};

	always_comb begin
		best_d     = '0;
		too_long_d = 1'b0;
		if (qlen_q == '0) begin
			best_d = BEST_W'(1);
		end else if (qovf_q || clen_q > CCAP) begin
			too_long_d = 1'b1;
		end else if (clen_q == '0) begin
			best_d = '0;
		end else if (chain_out.tok_val > {1'b0, BEST_MAX}) begin
			best_d = BEST_MAX;
		end else begin
			best_d = chain_out.tok_val[BEST_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qlen_q  <= '0;
			qovf_q  <= 1'b0;
			clen_q  <= '0;
			busy_q  <= 1'b0;
			link0_q <= '0;
			done_q  <= 1'b0;
		end else begin
			link0_q <= '0;
			done_q  <= 1'b0;
			if (is_clear) begin
				qlen_q <= '0;
				qovf_q <= 1'b0;
				clen_q <= '0;
			end
			if (is_append) begin
				if (qlen_q < QCAP) begin
					qlen_q <= qlen_q + QLW'(1);
				end else begin
					qovf_q <= 1'b1;
				end
				clen_q <= '0;
			end
			if (is_char) begin
				if (clen_q < CCAP) begin
					clen_q        <= clen_q + CLW'(1);
					link0_q.valid <= 1'b1;
					link0_q.ch    <= fold_case(char_byte);
				end else begin
					clen_q <= CCAP_SAT;
				end
			end
			if (is_end) begin
				link0_q.tok <= 1'b1;
				busy_q      <= 1'b1;
			end
			if (chain_out.tok) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
				clen_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chain_out.tok) begin
			best_q     <= best_d;
			matched_q  <= (best_d != '0);
			mlen_q     <= (best_d != '0) ? qlen_wide[MLEN_W-1:0] : '0;
			too_long_q <= too_long_d;
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign top_score    = best_q;
	assign matched      = matched_q;
	assign match_length = mlen_q;
	assign too_long     = too_long_q;

	`ASSERT_PROP(a_done_after_busy, clk, arst_n, done |-> $past(busy_q), "result without drain")
	`ASSERT_PROP(a_end_sets_busy, clk, arst_n, is_end |=> busy_q, "end word did not start drain")
	`ASSERT_PROP(a_matched_flag, clk, arst_n, done |-> (matched == (top_score != '0)), "matched flag wrong")
	`ASSERT_NEVER(a_long_no_match, clk, arst_n, done && matched && too_long, "overlong word matched")

endmodule

`default_nettype wire
